@@ rtl/core/rlgc_pkg.sv @@
// Shared constants, register codes and types for the lidar ray ground classifier.
// Used by rlgc_csr, rlgc_classify and lidar_ray_ground_classifier_unit; no dependencies.
`timescale 1ns / 1ps

package rlgc_pkg;

   localparam int RADIUS_BITS   = 17;
   localparam int INDEX_BITS    = 18;
   localparam int HEIGHT_BITS   = 16;
   localparam int TAN_BITS      = 17;
   localparam int MM12_BITS     = 12;
   localparam int FLOOR_BITS    = 17;
   localparam int FRAC_BITS     = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 17;

   // Derived datapath widths.
   localparam int PROD_BITS   = RADIUS_BITS + TAN_BITS;
   localparam int THR_BITS    = PROD_BITS - FRAC_BITS;
   localparam int MAG_BITS    = HEIGHT_BITS + 2;
   localparam int CMP_BITS    = (THR_BITS > MAG_BITS) ? THR_BITS : MAG_BITS;
   localparam int RCMP_BITS   = (RADIUS_BITS > FLOOR_BITS) ? RADIUS_BITS : FLOOR_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_SENSOR_HEIGHT  = CSR_IDX_BITS'(0),
      REG_LOCAL_TAN      = CSR_IDX_BITS'(1),
      REG_GENERAL_TAN    = CSR_IDX_BITS'(2),
      REG_FLOOR_RADIUS   = CSR_IDX_BITS'(3),
      REG_MIN_LOCAL_THR  = CSR_IDX_BITS'(4)
   } csr_reg_type;

   localparam logic [MM12_BITS-1:0]  RST_SENSOR_HEIGHT = MM12_BITS'(1750);
   localparam logic [TAN_BITS-1:0]   RST_LOCAL_TAN     = TAN_BITS'(9210);
   localparam logic [TAN_BITS-1:0]   RST_GENERAL_TAN   = TAN_BITS'(5734);
   localparam logic [FLOOR_BITS-1:0] RST_FLOOR_RADIUS  = FLOOR_BITS'(100);
   localparam logic [MM12_BITS-1:0]  RST_MIN_LOCAL_THR = MM12_BITS'(50);

   typedef struct packed {
      logic [MM12_BITS-1:0]  sensor_height_mm;
      logic [TAN_BITS-1:0]   local_slope_tangent;
      logic [TAN_BITS-1:0]   general_slope_tangent;
      logic [FLOOR_BITS-1:0] floor_radius_mm;
      logic [MM12_BITS-1:0]  min_local_threshold_mm;
   } cfg_type;

   typedef struct packed {
      logic [RADIUS_BITS-1:0]        last_radius;
      logic signed [HEIGHT_BITS-1:0] last_height;
      logic                          last_was_ground;
   } hist_type;

endpackage

@@ rtl/core/rlgc_csr.sv @@
// Configuration register file of the lidar ray ground classifier.
// Depends on rlgc_pkg for register codes, reset values and cfg_type.
`timescale 1ns / 1ps

module rlgc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [rlgc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [rlgc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output rlgc_pkg::cfg_type                    cfg
);

   rlgc_pkg::cfg_type cfg_ff;
   rlgc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            rlgc_pkg::REG_SENSOR_HEIGHT: begin
               cfg_in.sensor_height_mm = csr_wdata[rlgc_pkg::MM12_BITS-1:0];
            end
            rlgc_pkg::REG_LOCAL_TAN: begin
               cfg_in.local_slope_tangent = csr_wdata[rlgc_pkg::TAN_BITS-1:0];
            end
            rlgc_pkg::REG_GENERAL_TAN: begin
               cfg_in.general_slope_tangent = csr_wdata[rlgc_pkg::TAN_BITS-1:0];
            end
            rlgc_pkg::REG_FLOOR_RADIUS: begin
               cfg_in.floor_radius_mm = csr_wdata[rlgc_pkg::FLOOR_BITS-1:0];
            end
            rlgc_pkg::REG_MIN_LOCAL_THR: begin
               cfg_in.min_local_threshold_mm = csr_wdata[rlgc_pkg::MM12_BITS-1:0];
            end
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_height_mm       <= rlgc_pkg::RST_SENSOR_HEIGHT;
         cfg_ff.local_slope_tangent    <= rlgc_pkg::RST_LOCAL_TAN;
         cfg_ff.general_slope_tangent  <= rlgc_pkg::RST_GENERAL_TAN;
         cfg_ff.floor_radius_mm        <= rlgc_pkg::RST_FLOOR_RADIUS;
         cfg_ff.min_local_threshold_mm <= rlgc_pkg::RST_MIN_LOCAL_THR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/rlgc_classify.sv @@
// Combinational ground test for one point against the ray history.
// Depends on rlgc_pkg for widths, cfg_type and hist_type.
`timescale 1ns / 1ps

module rlgc_classify (
   input  rlgc_pkg::cfg_type                          cfg,
   input  rlgc_pkg::hist_type                         hist,
   input  logic                                       ray_start,
   input  logic [rlgc_pkg::RADIUS_BITS-1:0]           radius_mm,
   input  logic signed [rlgc_pkg::HEIGHT_BITS-1:0]    height_mm,
   output logic                                       is_ground
);

   localparam int RB = rlgc_pkg::RADIUS_BITS;
   localparam int HB = rlgc_pkg::HEIGHT_BITS;
   localparam int PB = rlgc_pkg::PROD_BITS;
   localparam int TB = rlgc_pkg::THR_BITS;
   localparam int MB = rlgc_pkg::MAG_BITS;
   localparam int CB = rlgc_pkg::CMP_BITS;
   localparam int FB = rlgc_pkg::FRAC_BITS;

   logic signed [HB-1:0] floor_height;
   logic [RB-1:0]        eff_radius;
   logic signed [HB-1:0] eff_height;
   logic                 eff_ground;
   logic                 step_ok;
   logic [RB-1:0]        step;
   logic [PB-1:0]        local_prod;
   logic [PB-1:0]        general_prod;
   logic [TB-1:0]        local_raw;
   logic [TB-1:0]        general_thr;
   logic [TB-1:0]        min_thr;
   logic [TB-1:0]        local_thr;
   logic                 beyond_floor;
   logic signed [MB-1:0] local_diff;
   logic signed [MB-1:0] floor_diff;
   logic [MB-1:0]        local_mag;
   logic [MB-1:0]        floor_mag;
   logic                 near_local;
   logic                 near_floor;

   always_comb begin
      floor_height = -$signed({{(HB - rlgc_pkg::MM12_BITS){1'b0}}, cfg.sensor_height_mm});

      // A new ray restarts from the floor under the sensor.
      eff_radius = ray_start ? '0 : hist.last_radius;
      eff_height = ray_start ? floor_height : hist.last_height;
      eff_ground = !ray_start && hist.last_was_ground;

      step_ok = radius_mm >= eff_radius;
      step    = radius_mm - eff_radius;

      local_prod   = PB'(step) * PB'(cfg.local_slope_tangent);
      general_prod = PB'(radius_mm) * PB'(cfg.general_slope_tangent);
      local_raw    = local_prod[PB-1:FB];
      general_thr  = general_prod[PB-1:FB];

      min_thr      = TB'(cfg.min_local_threshold_mm);
      beyond_floor = rlgc_pkg::RCMP_BITS'(radius_mm) >
                     rlgc_pkg::RCMP_BITS'(cfg.floor_radius_mm);
      local_thr    = (beyond_floor && (local_raw < min_thr)) ? min_thr : local_raw;

      local_diff = MB'(height_mm) - MB'(eff_height);
      floor_diff = MB'(height_mm) - MB'(floor_height);
      local_mag  = local_diff[MB-1] ? MB'(-local_diff) : MB'(local_diff);
      floor_mag  = floor_diff[MB-1] ? MB'(-floor_diff) : MB'(floor_diff);

      near_local = CB'(local_mag) <= CB'(local_thr);
      near_floor = CB'(floor_mag) <= CB'(general_thr);

      is_ground = step_ok && near_local && (eff_ground || near_floor);
   end

endmodule

@@ rtl/core/lidar_ray_ground_classifier_unit.sv @@
// Lidar ray ground classifier: one input register, one result register.
// An accepted item moves from the input register to the result register once that register frees up.
// Throughput: one item per cycle while rsp_ready holds; the ray history (radius, height, class)
// is updated as each item leaves the input register. Reset (synchronous): both stages empty,
// history cleared, registers at their default values. Depends on rlgc_pkg, rlgc_csr and rlgc_classify.
`timescale 1ns / 1ps

module lidar_ray_ground_classifier_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_ray_start,
   input  logic [rlgc_pkg::RADIUS_BITS-1:0]         req_radius_mm,
   input  logic signed [rlgc_pkg::HEIGHT_BITS-1:0]  req_height_mm,
   input  logic [rlgc_pkg::INDEX_BITS-1:0]          req_point_index,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [rlgc_pkg::INDEX_BITS-1:0]          rsp_index_out,
   output logic                                     rsp_is_ground,
   input  logic                                     csr_write_en,
   input  logic [rlgc_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [rlgc_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);

   rlgc_pkg::cfg_type  cfg;
   rlgc_pkg::hist_type hist_ff;
   rlgc_pkg::hist_type hist_in;

   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic                                    in_start_ff;
   logic [rlgc_pkg::RADIUS_BITS-1:0]        in_radius_ff;
   logic signed [rlgc_pkg::HEIGHT_BITS-1:0] in_height_ff;
   logic [rlgc_pkg::INDEX_BITS-1:0]         in_index_ff;

   logic                                    out_valid_ff;
   logic                                    out_valid_in;
   logic [rlgc_pkg::INDEX_BITS-1:0]         out_index_ff;
   logic                                    out_ground_ff;

   logic advance;
   logic take;
   logic ground;

   rlgc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rlgc_classify u_classify (
      .cfg       (cfg),
      .hist      (hist_ff),
      .ray_start (in_start_ff),
      .radius_mm (in_radius_ff),
      .height_mm (in_height_ff),
      .is_ground (ground)
   );

   // The item in the input register moves on whenever the result register frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || !out_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in  = take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
      hist_in      = hist_ff;
      if (advance) begin
         hist_in.last_radius     = in_radius_ff;
         hist_in.last_height     = in_height_ff;
         hist_in.last_was_ground = ground;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         hist_ff      <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_start_ff  <= req_ray_start;
         in_radius_ff <= req_radius_mm;
         in_height_ff <= req_height_mm;
         in_index_ff  <= req_point_index;
      end
      if (advance) begin
         out_index_ff  <= in_index_ff;
         out_ground_ff <= ground;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_index_out = out_index_ff;
   assign rsp_is_ground = out_ground_ff;

   // An empty result register never holds back the input side.
   assert property (@(posedge clock) disable iff (reset) !out_valid_ff |-> req_ready)
      else $error("input stalled while result register empty");

   // An item leaving the input register always shows up as a result.
   assert property (@(posedge clock) disable iff (reset) advance |=> rsp_valid)
      else $error("item lost between input and result registers");

   // A point closer than its predecessor on the same ray is never ground.
   assert property (@(posedge clock) disable iff (reset)
      advance && !in_start_ff && (in_radius_ff < hist_ff.last_radius) |=> !rsp_is_ground)
      else $error("negative radius step classified as ground");

   // The history always follows the point that was just classified.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (hist_ff.last_radius == $past(in_radius_ff)) &&
                  (hist_ff.last_was_ground == rsp_is_ground))
      else $error("ray history out of step with results");

endmodule
